// ----- rtl/core/afss_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// afss_pkg
// shared types and codes of the arming and flight-state sequencer
// ----------------------------------------------------------------------------
package afss_pkg;

  localparam int InDataW  = 144;
  localparam int OutDataW = 8;
  localparam int CfgAddrW = 5;

  // event kinds
  localparam logic [2:0] OP_CALIB  = 3'd0;
  localparam logic [2:0] OP_ARM    = 3'd1;
  localparam logic [2:0] OP_STICKS = 3'd2;
  localparam logic [2:0] OP_FLOW   = 3'd3;
  localparam logic [2:0] OP_ATT    = 3'd4;
  localparam logic [2:0] OP_FAST   = 3'd5;
  localparam logic [2:0] OP_SLOW   = 3'd6;

  // flight states
  localparam logic [2:0] ST_DISARMED = 3'd0;
  localparam logic [2:0] ST_ARMED    = 3'd1;
  localparam logic [2:0] ST_READY    = 3'd2;
  localparam logic [2:0] ST_TAKEOFF  = 3'd3;
  localparam logic [2:0] ST_FLYING   = 3'd4;
  localparam logic [2:0] ST_TESTING  = 3'd5;

  // result kinds
  localparam logic KIND_STATE = 1'b0;
  localparam logic KIND_CALIB = 1'b1;

  // register indexes
  localparam logic [2:0] REG_STICK_EXTREME = 3'd0;
  localparam logic [2:0] REG_THROTTLE_THR  = 3'd1;
  localparam logic [2:0] REG_FLOW_THR      = 3'd2;
  localparam logic [2:0] REG_TILT_LIMIT    = 3'd3;
  localparam logic [2:0] REG_CALIB_DELAY   = 3'd4;

  typedef struct packed {
    logic [13:0]        stick_extreme;
    logic signed [14:0] throttle_threshold;
    logic signed [31:0] flow_threshold;
    logic [14:0]        tilt_limit;
    logic [3:0]         calib_delay_ticks;
  } afss_cfg_t;

  typedef struct packed {
    logic       valid;
    logic       kind;
    logic [2:0] flight_state;
  } afss_result_t;

endpackage : afss_pkg
`default_nettype wire

// ----- rtl/core/afss_cfg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// afss_cfg
// configuration register bank behind the apb-style port
// ----------------------------------------------------------------------------
module afss_cfg
  import afss_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [CfgAddrW-1:0] paddr,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  output afss_cfg_t                cfg
);

  afss_cfg_t   cfg_r;
  logic        wr_en;
  logic [2:0]  reg_idx;

  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[CfgAddrW-1:2];
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.stick_extreme      <= 14'd9000;
      cfg_r.throttle_threshold <= 15'sd500;
      cfg_r.flow_threshold     <= 32'sd100;
      cfg_r.tilt_limit         <= 15'd6000;
      cfg_r.calib_delay_ticks  <= 4'd2;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_STICK_EXTREME: cfg_r.stick_extreme      <= pwdata[13:0];
        REG_THROTTLE_THR:  cfg_r.throttle_threshold <= pwdata[14:0];
        REG_FLOW_THR:      cfg_r.flow_threshold     <= pwdata;
        REG_TILT_LIMIT:    cfg_r.tilt_limit         <= pwdata[14:0];
        REG_CALIB_DELAY:   cfg_r.calib_delay_ticks  <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_STICK_EXTREME: prdata = {18'd0, cfg_r.stick_extreme};
      REG_THROTTLE_THR:  prdata = {17'd0, cfg_r.throttle_threshold};
      REG_FLOW_THR:      prdata = cfg_r.flow_threshold;
      REG_TILT_LIMIT:    prdata = {17'd0, cfg_r.tilt_limit};
      REG_CALIB_DELAY:   prdata = {28'd0, cfg_r.calib_delay_ticks};
      default:           prdata = 32'd0;
    endcase
  end

endmodule : afss_cfg
`default_nettype wire

// ----- rtl/core/afss_seq.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// afss_seq
// latched sensor state, flight-state machine and slow tick counter
// ----------------------------------------------------------------------------
module afss_seq
  import afss_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               item_en,
  input  wire logic [2:0]         op,
  input  wire logic [7:0]         calib_ok,
  input  wire logic [7:0]         arm_command,
  input  wire logic signed [14:0] stick_yaw,
  input  wire logic signed [14:0] stick_alt,
  input  wire logic signed [14:0] stick_roll,
  input  wire logic signed [14:0] stick_pitch,
  input  wire logic signed [31:0] flow_z,
  input  wire logic signed [15:0] att_roll,
  input  wire logic signed [15:0] att_pitch,
  input  wire afss_cfg_t          cfg,
  output afss_result_t            res
);

  logic [2:0]         mode_now_r, mode_now_nxt;
  logic [2:0]         mode_rep_r, mode_rep_nxt;
  logic [7:0]         arm_r, arm_nxt;
  logic [7:0]         arm_last_r, arm_last_nxt;
  logic signed [14:0] yaw_r, alt_r, roll_r, pitch_r;
  logic signed [14:0] yaw_nxt, alt_nxt, roll_nxt, pitch_nxt;
  logic signed [31:0] flow_r, flow_nxt;
  logic signed [15:0] att_roll_r, att_pitch_r, att_roll_nxt, att_pitch_nxt;
  logic               calib_r, calib_nxt;
  logic [4:0]         slow_cnt_r, slow_cnt_nxt;

  logic signed [15:0] ext_pos, ext_neg;
  logic               corner;
  logic [16:0]        mag_roll, mag_pitch;
  logic               tilted;
  logic [2:0]         m;

  assign ext_pos = $signed({2'b00, cfg.stick_extreme});
  assign ext_neg = -ext_pos;
  assign corner  = (16'(yaw_r) == ext_neg) && (16'(alt_r) == ext_neg) &&
                   (16'(roll_r) == ext_pos) && (16'(pitch_r) == ext_neg);

  assign mag_roll  = att_roll_r[15]  ? 17'(-$signed({att_roll_r[15], att_roll_r}))
                                     : {1'b0, att_roll_r};
  assign mag_pitch = att_pitch_r[15] ? 17'(-$signed({att_pitch_r[15], att_pitch_r}))
                                     : {1'b0, att_pitch_r};
  assign tilted = (mag_roll > {2'b00, cfg.tilt_limit}) ||
                  (mag_pitch > {2'b00, cfg.tilt_limit});

  always_comb begin
    mode_now_nxt  = mode_now_r;
    mode_rep_nxt  = mode_rep_r;
    arm_nxt       = arm_r;
    arm_last_nxt  = arm_last_r;
    yaw_nxt       = yaw_r;
    alt_nxt       = alt_r;
    roll_nxt      = roll_r;
    pitch_nxt     = pitch_r;
    flow_nxt      = flow_r;
    att_roll_nxt  = att_roll_r;
    att_pitch_nxt = att_pitch_r;
    calib_nxt     = calib_r;
    slow_cnt_nxt  = slow_cnt_r;
    res           = '0;
    m             = mode_now_r;
    if (item_en) begin
      unique case (op)
        OP_CALIB: begin
          if (calib_ok == 8'd1) begin
            calib_nxt = 1'b1;
          end else begin
            res.valid = 1'b1;
            res.kind  = KIND_CALIB;
          end
        end
        OP_ARM: arm_nxt = arm_command;
        OP_STICKS: begin
          yaw_nxt   = stick_yaw;
          alt_nxt   = stick_alt;
          roll_nxt  = stick_roll;
          pitch_nxt = stick_pitch;
        end
        OP_FLOW: flow_nxt = flow_z;
        OP_ATT: begin
          att_roll_nxt  = att_roll;
          att_pitch_nxt = att_pitch;
        end
        OP_FAST: begin
          if (arm_r == 8'd0) m = ST_DISARMED;
          if (arm_r == 8'd1 && arm_last_r == 8'd0 && calib_r) m = ST_ARMED;
          if (m == ST_ARMED && corner) m = ST_READY;
          if (m == ST_READY && alt_r > cfg.throttle_threshold) begin
            m = (arm_r == 8'd1) ? ST_TAKEOFF : ST_TESTING;
          end
          if (m == ST_TAKEOFF && flow_r > cfg.flow_threshold) m = ST_FLYING;
          mode_now_nxt = m;
          arm_last_nxt = arm_r;
          if (m != mode_rep_r) begin
            mode_rep_nxt     = m;
            res.valid        = 1'b1;
            res.kind         = KIND_STATE;
            res.flight_state = m;
          end
        end
        OP_SLOW: begin
          if (slow_cnt_r <= {1'b0, cfg.calib_delay_ticks}) begin
            if (slow_cnt_r == {1'b0, cfg.calib_delay_ticks}) begin
              res.valid = 1'b1;
              res.kind  = KIND_CALIB;
            end
            slow_cnt_nxt = slow_cnt_r + 5'd1;
          end
          if (tilted) mode_now_nxt = ST_DISARMED;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_now_r  <= ST_DISARMED;
      mode_rep_r  <= ST_DISARMED;
      arm_r       <= '0;
      arm_last_r  <= '0;
      yaw_r       <= '0;
      alt_r       <= '0;
      roll_r      <= '0;
      pitch_r     <= '0;
      flow_r      <= '0;
      att_roll_r  <= '0;
      att_pitch_r <= '0;
      calib_r     <= 1'b0;
      slow_cnt_r  <= '0;
    end else begin
      mode_now_r  <= mode_now_nxt;
      mode_rep_r  <= mode_rep_nxt;
      arm_r       <= arm_nxt;
      arm_last_r  <= arm_last_nxt;
      yaw_r       <= yaw_nxt;
      alt_r       <= alt_nxt;
      roll_r      <= roll_nxt;
      pitch_r     <= pitch_nxt;
      flow_r      <= flow_nxt;
      att_roll_r  <= att_roll_nxt;
      att_pitch_r <= att_pitch_nxt;
      calib_r     <= calib_nxt;
      slow_cnt_r  <= slow_cnt_nxt;
    end
  end

endmodule : afss_seq
`default_nettype wire

// ----- rtl/core/arming_flight_state_sequencer_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// arming_flight_state_sequencer_core
// event-driven arming sequencer: latches sensors and sticks, runs the
// flight-state machine at fast ticks and its tilt check at slow ticks, issues
// gyro calibration requests; a result is registered in the cycle after its item
// throughput: one item per cycle unless stalled, set by the single decision pass
// in_tready drops only while a finished result waits and out_tready is low
// synchronous active-low reset returns registers and state to their defaults
// ----------------------------------------------------------------------------
module arming_flight_state_sequencer_core
  import afss_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  // calib_ok, arm_command, stick_yaw, stick_alt, stick_roll, stick_pitch,
  // flow_z, att_roll, att_pitch, zero fill
  input  wire logic [InDataW-1:0]  in_tdata,
  // op
  input  wire logic [2:0]          in_tuser,
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  // flight_state, zero fill
  output logic [OutDataW-1:0]      out_tdata,
  // kind
  output logic                     out_tuser,
  input  wire logic                cfg_psel,
  input  wire logic                cfg_penable,
  input  wire logic                cfg_pwrite,
  input  wire logic [CfgAddrW-1:0] cfg_paddr,
  input  wire logic [31:0]         cfg_pwdata,
  output logic [31:0]              cfg_prdata,
  output logic                     cfg_pready
);

  afss_cfg_t    cfg;
  afss_result_t res;
  logic         accept;
  logic         out_valid_r;
  logic         out_kind_r;
  logic [2:0]   out_state_r;

  assign cfg_pready = 1'b1;
  assign in_tready  = !out_valid_r || out_tready;
  assign accept     = in_tvalid && in_tready;

  afss_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  afss_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_en     (accept),
    .op          (in_tuser),
    .calib_ok    (in_tdata[7:0]),
    .arm_command (in_tdata[15:8]),
    .stick_yaw   (in_tdata[30:16]),
    .stick_alt   (in_tdata[45:31]),
    .stick_roll  (in_tdata[60:46]),
    .stick_pitch (in_tdata[75:61]),
    .flow_z      (in_tdata[107:76]),
    .att_roll    (in_tdata[123:108]),
    .att_pitch   (in_tdata[139:124]),
    .cfg         (cfg),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      out_kind_r  <= res.kind;
      out_state_r <= res.flight_state;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {{(OutDataW-3){1'b0}}, out_state_r};

endmodule : arming_flight_state_sequencer_core
`default_nettype wire

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives event items into the arming and flight-state sequencer through its
// input stream and programs its registers over the APB port between phases.
// A local model of the sequencer predicts every state update and gyro
// calibration request. Each result is checked against the oldest prediction.
// A directed pass hits field extremes and corner cases. Random phases follow,
// under several register settings, built mostly from complete arming-to-flight
// runs mixed with noise. Both sides idle at random, and on the 30th of every
// 350 results the receiver holds off long enough to stall the input.
// ----------------------------------------------------------------------------
module testbench;
  import afss_pkg::*;

  localparam int IdleLimit = 2000;
  localparam int HoldCycles = 400;
  localparam int RandomItems = 1450;
  localparam int Phases = 5;
  localparam logic [2:0] OpUnused = 3'd7;

  typedef struct packed {
    logic [2:0]         op;
    logic [7:0]         calib_ok;
    logic [7:0]         arm_cmd;
    logic signed [14:0] yaw;
    logic signed [14:0] alt;
    logic signed [14:0] roll;
    logic signed [14:0] pitch;
    logic signed [31:0] flow;
    logic signed [15:0] att_roll;
    logic signed [15:0] att_pitch;
  } event_t;

  typedef struct packed {
    logic       kind;
    logic [2:0] state;
  } report_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic [InDataW-1:0]  in_tdata = '0;
  logic [2:0]          in_tuser = '0;
  logic                out_tready = 1'b0;
  logic                cfg_psel = 1'b0;
  logic                cfg_penable = 1'b0;
  logic                cfg_pwrite = 1'b0;
  logic [CfgAddrW-1:0] cfg_paddr = '0;
  logic [31:0]         cfg_pwdata = '0;
  wire                 in_tready;
  wire                 out_tvalid;
  wire [OutDataW-1:0]  out_tdata;
  wire                 out_tuser;
  wire [31:0]          cfg_prdata;
  wire                 cfg_pready;

  arming_flight_state_sequencer_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #10 clk = ~clk;

  // register copies
  logic [13:0]        cfg_extreme = 14'd9000;
  logic signed [14:0] cfg_throttle = 15'sd500;
  logic signed [31:0] cfg_flow = 32'sd100;
  logic [14:0]        cfg_tilt = 15'd6000;
  logic [3:0]         cfg_delay = 4'd2;

  // sequencer model state
  logic [2:0]         mode_cur = ST_DISARMED;
  logic [2:0]         mode_sent = ST_DISARMED;
  logic [7:0]         arm_cur = 8'd0;
  logic [7:0]         arm_prev = 8'd0;
  logic signed [14:0] st_yaw = '0;
  logic signed [14:0] st_alt = '0;
  logic signed [14:0] st_roll = '0;
  logic signed [14:0] st_pitch = '0;
  logic signed [31:0] flow_cur = '0;
  logic signed [15:0] att_roll_cur = '0;
  logic signed [15:0] att_pitch_cur = '0;
  bit                 gyro_ok = 1'b0;
  logic [4:0]         slow_count = 5'd0;

  event_t  pending_events[$];
  report_t expected_reports[$];
  event_t  driven_event = '0;
  int      queued_items = 0;
  int      mismatches = 0;
  int      idle_cycles = 0;
  logic    in_fire = 1'b0;
  logic    out_fire = 1'b0;
  int      in_gap = 0;
  bit      in_burst = 1'b0;
  int      out_wait = 0;
  int      hold_left = 0;
  int      results_taken = 0;
  bit      out_burst = 1'b0;

  function automatic bit sequencer_step(input event_t ev, output report_t rep);
    int  ext;
    int  r;
    int  p;
    bit  produced;
    produced = 1'b0;
    rep.kind = KIND_STATE;
    rep.state = ST_DISARMED;
    ext = int'(cfg_extreme);
    case (ev.op)
      OP_CALIB: begin
        if (ev.calib_ok == 8'd1) gyro_ok = 1'b1;
        else begin
          rep.kind = KIND_CALIB;
          produced = 1'b1;
        end
      end
      OP_ARM: arm_cur = ev.arm_cmd;
      OP_STICKS: begin
        st_yaw = ev.yaw;
        st_alt = ev.alt;
        st_roll = ev.roll;
        st_pitch = ev.pitch;
      end
      OP_FLOW: flow_cur = ev.flow;
      OP_ATT: begin
        att_roll_cur = ev.att_roll;
        att_pitch_cur = ev.att_pitch;
      end
      OP_FAST: begin
        if (arm_cur == 8'd0) mode_cur = ST_DISARMED;
        if (arm_cur == 8'd1 && arm_prev == 8'd0 && gyro_ok) mode_cur = ST_ARMED;
        if (mode_cur == ST_ARMED && int'(st_yaw) == -ext && int'(st_alt) == -ext &&
            int'(st_roll) == ext && int'(st_pitch) == -ext)
          mode_cur = ST_READY;
        if (mode_cur == ST_READY && st_alt > cfg_throttle)
          mode_cur = (arm_cur == 8'd1) ? ST_TAKEOFF : ST_TESTING;
        if (mode_cur == ST_TAKEOFF && flow_cur > cfg_flow) mode_cur = ST_FLYING;
        arm_prev = arm_cur;
        if (mode_cur != mode_sent) begin
          mode_sent = mode_cur;
          rep.state = mode_cur;
          produced = 1'b1;
        end
      end
      OP_SLOW: begin
        if (slow_count <= {1'b0, cfg_delay}) begin
          if (slow_count == {1'b0, cfg_delay}) begin
            rep.kind = KIND_CALIB;
            produced = 1'b1;
          end
          slow_count = slow_count + 5'd1;
        end
        r = int'(att_roll_cur);
        p = int'(att_pitch_cur);
        if (r < 0) r = -r;
        if (p < 0) p = -p;
        if (r > int'(cfg_tilt) || p > int'(cfg_tilt)) mode_cur = ST_DISARMED;
      end
      default: ;
    endcase
    return produced;
  endfunction

  function automatic logic signed [14:0] rand_stick();
    if ($urandom_range(0, 15) == 0) return 15'($urandom());
    return 15'(int'($urandom_range(0, 18000)) - 9000);
  endfunction

  function automatic logic signed [15:0] rand_angle();
    if ($urandom_range(0, 15) == 0) return 16'($urandom());
    return 16'(int'($urandom_range(0, 36000)) - 18000);
  endfunction

  function automatic logic signed [15:0] calm_angle();
    int t;
    t = int'(cfg_tilt);
    return 16'(int'($urandom_range(0, 2 * t)) - t);
  endfunction

  function automatic event_t random_event(input logic [2:0] op);
    event_t ev;
    ev.op = op;
    ev.calib_ok = $urandom_range(0, 1) ? 8'd1 : 8'($urandom());
    case ($urandom_range(0, 2))
      0: ev.arm_cmd = 8'd0;
      1: ev.arm_cmd = 8'd1;
      default: ev.arm_cmd = 8'($urandom());
    endcase
    ev.yaw = rand_stick();
    ev.alt = rand_stick();
    ev.roll = rand_stick();
    ev.pitch = rand_stick();
    ev.flow = $urandom();
    ev.att_roll = rand_angle();
    ev.att_pitch = rand_angle();
    return ev;
  endfunction

  task automatic queue_event(input event_t ev);
    pending_events.push_back(ev);
    if (ev.op != OpUnused) queued_items++;
  endtask

  task automatic queue_op(input logic [2:0] op);
    queue_event(random_event(op));
  endtask

  task automatic queue_calib(input logic [7:0] v);
    event_t ev;
    ev = random_event(OP_CALIB);
    ev.calib_ok = v;
    queue_event(ev);
  endtask

  task automatic queue_arm(input logic [7:0] v);
    event_t ev;
    ev = random_event(OP_ARM);
    ev.arm_cmd = v;
    queue_event(ev);
  endtask

  task automatic queue_sticks(input logic signed [14:0] y, input logic signed [14:0] a,
                              input logic signed [14:0] r, input logic signed [14:0] p);
    event_t ev;
    ev = random_event(OP_STICKS);
    ev.yaw = y;
    ev.alt = a;
    ev.roll = r;
    ev.pitch = p;
    queue_event(ev);
  endtask

  task automatic queue_flow(input logic signed [31:0] f);
    event_t ev;
    ev = random_event(OP_FLOW);
    ev.flow = f;
    queue_event(ev);
  endtask

  task automatic queue_att(input logic signed [15:0] r, input logic signed [15:0] p);
    event_t ev;
    ev = random_event(OP_ATT);
    ev.att_roll = r;
    ev.att_pitch = p;
    queue_event(ev);
  endtask

  // calibrate, arm, corner, lift off, climb, then maybe tilt or disarm
  task automatic queue_flight_run();
    int                 ext;
    int                 t;
    int                 hi;
    int                 m;
    longint             fl;
    logic signed [14:0] lift;
    logic signed [15:0] steep;
    ext = int'(cfg_extreme);
    if ($urandom_range(0, 7) != 0) queue_calib(8'd1);
    else queue_calib(8'($urandom()));
    queue_arm(8'd0);
    queue_op(OP_FAST);
    if ($urandom_range(0, 1)) queue_att(calm_angle(), calm_angle());
    queue_arm($urandom_range(0, 4) != 0 ? 8'd1 : 8'($urandom()));
    queue_op(OP_FAST);
    if ($urandom_range(0, 9) == 0) queue_event(random_event(3'($urandom_range(0, 7))));
    if ($urandom_range(0, 9) != 0) queue_sticks(15'(-ext), 15'(-ext), 15'(ext), 15'(-ext));
    else queue_sticks(rand_stick(), 15'(-ext), 15'(ext), 15'(-ext));
    queue_op(OP_FAST);
    if ($urandom_range(0, 2) == 0) queue_op(OP_SLOW);
    if ($urandom_range(0, 3) == 0) queue_arm(8'($urandom_range(2, 255)));
    t = int'(cfg_throttle);
    if (t >= 16383) lift = 15'sd16383;
    else begin
      hi = (t < 9000) ? 9000 : 16383;
      lift = 15'(t + 1 + int'($urandom_range(0, hi - t - 1)));
    end
    if ($urandom_range(0, 7) == 0) lift = rand_stick();
    queue_sticks(rand_stick(), lift, rand_stick(), rand_stick());
    queue_op(OP_FAST);
    fl = longint'(cfg_flow) + 1 + longint'($urandom_range(0, 5000));
    if (fl > 64'sd2147483647) fl = 64'sd2147483647;
    if ($urandom_range(0, 4) == 0) queue_flow($urandom());
    else queue_flow(32'(fl));
    queue_op(OP_FAST);
    repeat ($urandom_range(0, 3)) queue_op($urandom_range(0, 1) ? OP_FAST : OP_SLOW);
    if ($urandom_range(0, 3) == 0) begin
      t = int'(cfg_tilt);
      if (t >= 32767) steep = -16'sd32768;
      else begin
        m = t + 1 + int'($urandom_range(0, 32767 - t - 1));
        steep = $urandom_range(0, 1) ? 16'(m) : 16'(-m);
      end
      queue_att(steep, rand_angle());
      queue_op(OP_SLOW);
      queue_op(OP_FAST);
    end
    if ($urandom_range(0, 1)) begin
      queue_arm(8'd0);
      queue_op(OP_FAST);
    end
  endtask

  task automatic queue_random_traffic(input int target);
    int start;
    start = queued_items;
    while (queued_items - start < target) begin
      if ($urandom_range(0, 3) != 0) queue_flight_run();
      else repeat ($urandom_range(1, 6)) queue_op(3'($urandom_range(0, 7)));
    end
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] value);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  task automatic program_regs(input logic [13:0] ext, input logic signed [14:0] thr,
                              input logic signed [31:0] fl, input logic [14:0] tilt,
                              input logic [3:0] dly);
    cfg_write(REG_STICK_EXTREME, {18'd0, ext});
    cfg_write(REG_THROTTLE_THR, {{17{thr[14]}}, thr});
    cfg_write(REG_FLOW_THR, fl);
    cfg_write(REG_TILT_LIMIT, {17'd0, tilt});
    cfg_write(REG_CALIB_DELAY, {28'd0, dly});
    cfg_extreme = ext;
    cfg_throttle = thr;
    cfg_flow = fl;
    cfg_tilt = tilt;
    cfg_delay = dly;
  endtask

  task automatic wait_idle();
    while (pending_events.size() != 0 || in_tvalid || expected_reports.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic log_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch at %0t: %s", $time, msg);
  endtask

  always @(negedge clk) begin : driver
    event_t ev;
    if (!rst_n) in_tvalid <= 1'b0;
    else if (in_tvalid && !in_fire) begin
    end else if (in_gap > 0) begin
      in_gap--;
      in_tvalid <= 1'b0;
    end else if (pending_events.size() != 0) begin
      ev = pending_events.pop_front();
      driven_event <= ev;
      in_tdata <= {4'd0, ev.att_pitch, ev.att_roll, ev.flow, ev.pitch, ev.roll, ev.alt,
                   ev.yaw, ev.arm_cmd, ev.calib_ok};
      in_tuser <= ev.op;
      in_tvalid <= 1'b1;
      if ($urandom_range(0, 39) == 0) in_burst = !in_burst;
      in_gap = in_burst ? 0 : $urandom_range(0, 13);
    end else in_tvalid <= 1'b0;
  end

  always @(negedge clk) begin : receiver
    if (out_fire) begin
      results_taken++;
      // long hold-off so the output register fills and the input stalls
      if (results_taken % 350 == 30) hold_left = HoldCycles;
      if ($urandom_range(0, 39) == 0) out_burst = !out_burst;
      out_wait = out_burst ? 0 : $urandom_range(0, 13);
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (out_wait > 0) begin
      out_wait--;
      out_tready <= 1'b0;
    end else out_tready <= 1'b1;
  end

  always @(posedge clk) begin : monitor
    report_t rep;
    report_t want;
    in_fire <= rst_n && in_tvalid && in_tready;
    out_fire <= rst_n && out_tvalid && out_tready;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        if (sequencer_step(driven_event, rep)) expected_reports.push_back(rep);
      end
      if (out_tvalid && out_tready) begin
        if (expected_reports.size() == 0)
          log_mismatch($sformatf("unexpected item kind %0d data %0h", out_tuser, out_tdata));
        else begin
          want = expected_reports.pop_front();
          if (out_tuser !== want.kind || out_tdata !== {5'd0, want.state})
            log_mismatch($sformatf("kind exp %0d got %0d, state exp %0d got %0h",
                                   want.kind, out_tuser, want.state, out_tdata));
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_psel && cfg_penable && cfg_pready))
      idle_cycles <= 0;
    else if (idle_cycles >= IdleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end else idle_cycles <= idle_cycles + 1;
  end

  initial begin : stimulus
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed pass under reset settings
    queue_calib(8'd0);
    queue_calib(8'd255);
    queue_op(OpUnused);
    queue_arm(8'd1);
    queue_op(OP_FAST);
    queue_calib(8'd1);
    queue_arm(8'd0);
    queue_op(OP_FAST);
    queue_arm(8'd1);
    queue_op(OP_FAST);
    queue_sticks(-15'sd9000, -15'sd9000, 15'sd9000, -15'sd9000);
    queue_op(OP_FAST);
    queue_sticks(15'sd0, 15'sd9000, 15'sd0, 15'sd0);
    queue_op(OP_FAST);
    queue_flow(32'sh7fff_ffff);
    queue_op(OP_FAST);
    queue_att(-16'sd18000, 16'sd18000);
    queue_op(OP_SLOW);
    queue_op(OP_FAST);
    queue_op(OP_SLOW);
    queue_op(OP_SLOW);
    queue_arm(8'd0);
    queue_op(OP_FAST);
    queue_arm(8'd1);
    queue_op(OP_FAST);
    queue_sticks(-15'sd9000, -15'sd9000, 15'sd9000, -15'sd9000);
    queue_op(OP_FAST);
    queue_arm(8'd255);
    queue_sticks(-15'sd9000, 15'sd9000, -15'sd9000, 15'sd9000);
    queue_op(OP_FAST);
    queue_flow(32'sh8000_0000);
    queue_arm(8'd0);
    queue_op(OP_FAST);

    for (int ph = 0; ph < Phases; ph++) begin
      wait_idle();
      case (ph)
        0: program_regs(14'd0, -15'sd9000, 32'sh8000_0000, 15'd0, 4'd4);
        1: program_regs(14'd9000, 15'sd9000, 32'sh7fff_ffff, 15'd18000, 4'd9);
        default: program_regs(14'($urandom_range(0, 9000)),
                              15'(int'($urandom_range(0, 18000)) - 9000),
                              $urandom(), 15'($urandom_range(0, 18000)),
                              ph == 2 ? 4'd15 : 4'($urandom_range(0, 15)));
      endcase
      queue_random_traffic(RandomItems / Phases);
    end

    wait_idle();
    repeat (10) @(posedge clk);
    if (mismatches == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
